### rtl/sidal_pkg.sv
`timescale 1ns / 1ps
// shared constants, mode codes and control structs for the session id allocator
// no dependencies

package sidal_pkg;

    localparam int ID_W   = 16;
    localparam int MODE_W = 2;

    localparam int DEF_NUM_IDS = 256;
    localparam int DEF_ID_BASE = 1000;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    // stack request issued at input accept
    typedef struct packed {
        logic pop;
        logic push;
    } t_stack_op;

    // active bit write from the commit stage
    typedef struct packed {
        logic en;
        logic data;
    } t_act_wr;

endpackage

### rtl/sidal_stack.sv
`timescale 1ns / 1ps
// free id stack: memory, fill count and low-water mark for untouched entries
// depends on sidal_pkg

module sidal_stack #(
    parameter int NUM_IDS = sidal_pkg::DEF_NUM_IDS,
    parameter int ID_BASE = sidal_pkg::DEF_ID_BASE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sidal_pkg::t_stack_op      i_op,
    input  logic [sidal_pkg::ID_W-1:0] i_push_id,
    output logic                      o_empty,
    output logic                      o_full,
    output logic [sidal_pkg::ID_W-1:0] o_top
);
    import sidal_pkg::*;

    localparam int CNT_W = $clog2(NUM_IDS + 1);
    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_IDS);
    localparam logic [ID_W-1:0]  BASE_ID  = ID_W'(ID_BASE);

    logic [ID_W-1:0]  r_mem [NUM_IDS];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_low, n_low;
    logic [ID_W-1:0]  r_rd;
    logic [ID_W-1:0]  r_init_val;
    logic             r_use_init;
    logic [CNT_W-1:0] w_dec;
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_wr_idx;

    assign w_dec    = r_count - 1'b1;
    assign w_rd_idx = w_dec[IDX_W-1:0];
    assign w_wr_idx = r_count[IDX_W-1:0];
    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == FULL_CNT);

    always_comb begin
        n_count = r_count;
        n_low   = r_low;
        if (i_op.pop) begin
            n_count = w_dec;
            if (w_dec < r_low) begin
                n_low = w_dec;
            end
        end else if (i_op.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= FULL_CNT;
            r_low   <= FULL_CNT;
        end else begin
            r_count <= n_count;
            r_low   <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[w_wr_idx] <= i_push_id;
        end
    end

    // entries never popped are served from their reset id, not from memory
    always_ff @(posedge i_clk) begin
        if (i_op.pop) begin
            r_rd       <= r_mem[w_rd_idx];
            r_use_init <= (r_low == r_count);
            r_init_val <= BASE_ID + ID_W'(w_dec);
        end
    end

    assign o_top = r_use_init ? r_init_val : r_rd;

endmodule

### rtl/sidal_active.sv
`timescale 1ns / 1ps
// active bit memory with clearing pass after reset and write forwarding
// depends on sidal_pkg

module sidal_active #(
    parameter int NUM_IDS = sidal_pkg::DEF_NUM_IDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [((NUM_IDS > 1) ? $clog2(NUM_IDS) : 1)-1:0] i_rd_addr,
    input  sidal_pkg::t_act_wr   i_wr,
    input  logic [((NUM_IDS > 1) ? $clog2(NUM_IDS) : 1)-1:0] i_wr_addr,
    output logic                 o_rd_flag,
    output logic                 o_busy
);
    import sidal_pkg::*;

    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);

    logic             r_mem [NUM_IDS];
    logic             r_busy;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_mem_q;
    logic             r_hit;
    logic             r_hit_val;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_wdata;

    assign w_we    = r_busy | i_wr.en;
    assign w_waddr = r_busy ? r_clr_idx : i_wr_addr;
    assign w_wdata = r_busy ? 1'b0 : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q   <= r_mem[i_rd_addr];
            r_hit     <= i_wr.en && (i_wr_addr == i_rd_addr);
            r_hit_val <= i_wr.data;
        end
    end

    assign o_rd_flag = r_hit ? r_hit_val : r_mem_q;
    assign o_busy    = r_busy;

endmodule

### rtl/session_id_free_list_allocator.sv
`timescale 1ns / 1ps
// session id allocator: LIFO free stack of ids plus one active bit per id
// depends on sidal_pkg, sidal_stack, sidal_active
//
// usage
//   request channel i_valid / o_ready carries i_mode (allocate, release, set
//   active bit, query active bit), i_session_id and i_active_value
//   result channel o_valid / i_ready carries o_ok, o_id_out, o_active_flag,
//   exactly one result item per request item, in order
//   a result passes the commit stage and the result register before it is shown
//   throughput: one item per cycle while o_ready is high; the stack pointer
//   moves at accept time, so a pop right after a push reads the freshly
//   written entry, and the active bit memory forwards the write of the
//   item ahead of it; after reset the stack is full with the highest id on
//   top; entries never popped are served from their reset id, so the stack
//   needs no fill; reset also starts a clearing pass over all NUM_IDS
//   active bits (256 at the default), during which o_ready stays low
//   a stalled receiver holds the result register; one more item waits in
//   the commit stage, after which o_ready drops until the result is taken

module session_id_free_list_allocator #(
    parameter int NUM_IDS = sidal_pkg::DEF_NUM_IDS,
    parameter int ID_BASE = sidal_pkg::DEF_ID_BASE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sidal_pkg::MODE_W-1:0]  i_mode,
    input  logic [sidal_pkg::ID_W-1:0]    i_session_id,
    input  logic                          i_active_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_ok,
    output logic [sidal_pkg::ID_W-1:0]    o_id_out,
    output logic                          o_active_flag
);
    import sidal_pkg::*;

    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam logic [ID_W:0] BASE_X  = (ID_W + 1)'(ID_BASE);
    localparam logic [ID_W:0] LIMIT_X = (ID_W + 1)'(ID_BASE + NUM_IDS);

    // id range check without wraparound
    function automatic logic f_in_range(input logic [ID_W-1:0] id);
        logic [ID_W:0] x;
        x = {1'b0, id};
        return (x >= BASE_X) && (x < LIMIT_X);
    endfunction

    // input decode
    logic             w_accept;
    logic             w_adv;
    logic             w_busy;
    logic             w_empty;
    logic             w_full;
    logic             w_inr;
    logic [ID_W:0]    w_in_diff;
    logic [IDX_W-1:0] w_in_slot;
    logic             w_ok_pre;
    t_stack_op        w_sop;

    // commit stage
    logic              r_s1_v;
    logic [MODE_W-1:0] r_s1_mode;
    logic              r_s1_inr;
    logic              r_s1_ok;
    logic [IDX_W-1:0]  r_s1_slot;
    logic              r_s1_val;

    logic [ID_W-1:0]  w_top;
    logic [ID_W:0]    w_top_diff;
    logic             w_top_inr;
    logic             w_act_flag;
    t_act_wr          w_awr;
    logic [IDX_W-1:0] w_awr_addr;
    logic [ID_W-1:0]  w_id_res;
    logic             w_flag_res;

    // result register
    logic            r_out_v;
    logic            r_out_ok;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_flag;

    assign w_adv    = !r_out_v || i_ready;
    assign o_ready  = !w_busy && (!r_s1_v || w_adv);
    assign w_accept = i_valid && o_ready;

    assign w_inr     = f_in_range(i_session_id);
    assign w_in_diff = {1'b0, i_session_id} - BASE_X;
    assign w_in_slot = w_in_diff[IDX_W-1:0];

    // stack moves at accept time so back-to-back items see each other
    always_comb begin
        w_sop    = '0;
        w_ok_pre = 1'b0;
        case (i_mode)
            MODE_ALLOC: begin
                w_sop.pop = w_accept && !w_empty;
                w_ok_pre  = !w_empty;
            end
            MODE_RELEASE: begin
                w_sop.push = w_accept && w_inr && !w_full;
                w_ok_pre   = w_inr && !w_full;
            end
            MODE_SET, MODE_QUERY: begin
                w_ok_pre = w_inr;
            end
            default: begin
                w_ok_pre = 1'b0;
            end
        endcase
    end

    sidal_stack #(
        .NUM_IDS (NUM_IDS),
        .ID_BASE (ID_BASE)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_sop),
        .i_push_id (i_session_id),
        .o_empty   (w_empty),
        .o_full    (w_full),
        .o_top     (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_accept) begin
            r_s1_v <= 1'b1;
        end else if (w_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mode <= i_mode;
            r_s1_inr  <= w_inr;
            r_s1_ok   <= w_ok_pre;
            r_s1_slot <= w_in_slot;
            r_s1_val  <= i_active_value;
        end
    end

    // popped id is normally in range; a wrapped reset id is not
    assign w_top_inr  = f_in_range(w_top);
    assign w_top_diff = {1'b0, w_top} - BASE_X;

    // active bit update, written only when the item commits
    always_comb begin
        w_awr      = '0;
        w_awr_addr = r_s1_slot;
        w_id_res   = '0;
        w_flag_res = 1'b0;
        case (r_s1_mode)
            MODE_ALLOC: begin
                w_awr.en   = r_s1_v && w_adv && r_s1_ok && w_top_inr;
                w_awr.data = 1'b1;
                w_awr_addr = w_top_diff[IDX_W-1:0];
                w_id_res   = r_s1_ok ? w_top : '0;
            end
            MODE_RELEASE: begin
                w_awr.en   = r_s1_v && w_adv && r_s1_inr;
                w_awr.data = 1'b0;
            end
            MODE_SET: begin
                w_awr.en   = r_s1_v && w_adv && r_s1_inr;
                w_awr.data = r_s1_val;
            end
            MODE_QUERY: begin
                w_flag_res = r_s1_inr && w_act_flag;
            end
            default: begin
                w_awr = '0;
            end
        endcase
    end

    sidal_active #(
        .NUM_IDS (NUM_IDS)
    ) u_active (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_slot),
        .i_wr      (w_awr),
        .i_wr_addr (w_awr_addr),
        .o_rd_flag (w_act_flag),
        .o_busy    (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_v) begin
            r_out_ok   <= r_s1_ok;
            r_out_id   <= w_id_res;
            r_out_flag <= w_flag_res;
        end
    end

    assign o_valid       = r_out_v;
    assign o_ok          = r_out_ok;
    assign o_id_out      = r_out_id;
    assign o_active_flag = r_out_flag;

endmodule

### rtl/sidal_checker.sv
`timescale 1ns / 1ps
// port-level checks for the session id allocator, bound to the top level
// depends on sidal_pkg and session_id_free_list_allocator

module sidal_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_ok,
    input logic [sidal_pkg::ID_W-1:0]   o_id_out,
    input logic                         o_active_flag
);
    import sidal_pkg::*;

    // accepted item must lead to a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##2 o_valid)
        else $error("result missing two cycles after accept");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ok) && $stable(o_id_out)
                                   && $stable(o_active_flag)))
        else $error("stalled result changed");

    // failed item never carries an id
    a_fail_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_id_out == '0))
        else $error("failed result carries an id");

    // an active flag only comes from a successful query
    a_flag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_active_flag) |-> (o_ok && (o_id_out == '0)))
        else $error("active flag on a failed or allocate result");

endmodule

bind session_id_free_list_allocator sidal_checker u_sidal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ok          (o_ok),
    .o_id_out      (o_id_out),
    .o_active_flag (o_active_flag)
);
